[src/gsme_pkg.sv]
// Shared types and constants of the graph segment merge engine.
// No dependencies; used by graph_segment_merge_engine_unit and its bench.
package gsme_pkg;

    // Default geometry
    localparam int MAX_NODES_DEF = 65536;
    localparam int FRAC_BITS_DEF = 7;

    // Fixed field widths
    localparam int NODE_W  = 16;
    localparam int SIZE_W  = 17;
    localparam int TH_W    = 24;
    localparam int WGT_W   = 16;
    localparam int K_W     = 16;
    localparam int CFG_W   = 17;

    // Request codes
    typedef enum logic [1:0] {
        REQ_MERGE   = 2'd0,
        REQ_SMALL   = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_MERGE_K    = 2'd1,
        CFG_MIN_SIZE   = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FA_RD,
        S_FA_CK,
        S_FB_RD,
        S_FB_CK,
        S_RD_A,
        S_RD_B,
        S_LAT_B,
        S_EVAL,
        S_DIV,
        S_TH_WR,
        S_FN_RD,
        S_FN_CK,
        S_SZ_RD,
        S_SZ_LAT,
        S_DONE
    } t_state;

endpackage

[src/gsme_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gsme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/graph_segment_merge_engine_unit.sv]
// Graph segment merge engine top level: union-find sequencer over three RAMs.
// Depends on gsme_pkg and gsme_ram.

// One request is worked on at a time. The parent, size and threshold stores
// each sit in a RAM with one read and one write port, so every step of a root
// walk has an address state and a compare state. A merge edge walks the trees
// of node_a and node_b, fetches both roots, and after a join runs the
// bit-serial divider for the new threshold before a final walk for node_a; a
// small-pass edge skips the divider and the threshold write, and a query
// does only the final walk and the size fetch. Union by size keeps depths at
// most log2 of the component size. A restart also clears the nodes in use.
// After reset the block runs a clearing pass over all MAX_NODES nodes before
// it takes its first request; configuration writes are taken throughout. A
// finished result sits in an output register, so the next request is
// accepted while it waits to be taken.
module graph_segment_merge_engine_unit #(
    parameter int MAX_NODES = gsme_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = gsme_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [gsme_pkg::CFG_W-1:0]  i_cfg_data,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [gsme_pkg::NODE_W-1:0] i_node_a,
    input  logic [gsme_pkg::NODE_W-1:0] i_node_b,
    input  logic [gsme_pkg::WGT_W-1:0]  i_weight,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [gsme_pkg::NODE_W-1:0] o_root_label,
    output logic                        o_merged,
    output logic [gsme_pkg::SIZE_W-1:0] o_component_size
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = (CW > gsme_pkg::SIZE_W) ? CW : gsme_pkg::SIZE_W;
    localparam int DW  = gsme_pkg::K_W + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int TW  = gsme_pkg::TH_W;
    localparam int SW  = gsme_pkg::SIZE_W;
    localparam int NW  = gsme_pkg::NODE_W;
    localparam logic [TW-1:0] TH_MAX   = {TW{1'b1}};
    localparam logic [SW-1:0] SIZE_MAX = {SW{1'b1}};
    localparam logic [SW-1:0] SIZE_ONE = SW'(1);

    // Saturated K scaled into the threshold format
    function automatic logic [TW-1:0] f_scale(input logic [gsme_pkg::K_W-1:0] k);
        logic [DW-1:0] v;
        v = DW'(k) << FRAC_BITS;
        if ((DW > TW) && ((v >> TW) != '0)) begin
            return TH_MAX;
        end
        return TW'(v);
    endfunction

    // Registers
    gsme_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_ci, n_ci, r_clim, n_clim;
    logic             r_restart, n_restart;
    logic [TW-1:0]    r_sk, n_sk;
    logic [SW-1:0]    r_node_count;
    logic [gsme_pkg::K_W-1:0] r_k;
    logic [SW-1:0]    r_min;
    logic [1:0]       r_req, n_req;
    logic [NW-1:0]    r_na, n_na, r_nb, n_nb;
    logic [gsme_pkg::WGT_W-1:0] r_w, n_w;
    logic [AW-1:0]    r_x, n_x, r_ra, n_ra, r_rb, n_rb, r_keep, n_keep;
    logic [SW-1:0]    r_sa, n_sa, r_sb, n_sb, r_sum, n_sum;
    logic [TW-1:0]    r_ta, n_ta, r_tb, n_tb;
    logic [SW:0]      r_rem, n_rem;
    logic [DW-1:0]    r_quo, n_quo;
    logic [DCW-1:0]   r_dcnt, n_dcnt;
    logic             r_merged, n_merged;
    logic [NW-1:0]    r_res_root, n_res_root;
    logic [SW-1:0]    r_res_size, n_res_size;
    logic             r_ovalid, n_ovalid;
    logic [NW-1:0]    r_oroot, n_oroot;
    logic             r_omerged, n_omerged;
    logic [SW-1:0]    r_osize, n_osize;

    // Memory ports
    logic          p_we, s_we, t_we;
    logic [AW-1:0] p_waddr, s_waddr, t_waddr;
    logic [AW-1:0] p_wdata;
    logic [SW-1:0] s_wdata;
    logic [TW-1:0] t_wdata;
    logic [AW-1:0] p_raddr, st_raddr;
    logic [AW-1:0] p_rdata;
    logic [SW-1:0] s_rdata;
    logic [TW-1:0] t_rdata;

    gsme_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    gsme_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(st_raddr), .o_rdata(s_rdata)
    );
    gsme_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_thresh (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(st_raddr), .o_rdata(t_rdata)
    );

    // Effective node count, clamped to 1..MAX_NODES
    logic [EW-1:0] nc_ext;
    logic [CW-1:0] eff_n;
    always_comb begin
        nc_ext = EW'(r_node_count);
        if (nc_ext == '0) begin
            eff_n = CW'(1);
        end else if (nc_ext > EW'(MAX_NODES)) begin
            eff_n = CW'(MAX_NODES);
        end else begin
            eff_n = CW'(nc_ext);
        end
    end

    // Divider step and threshold sum
    logic [SW:0]   div_t;
    logic          div_ge;
    logic [DW:0]   th_sum;
    logic [TW-1:0] th_new;
    logic [SW:0]   sz_sum;
    logic [SW-1:0] sz_sat;
    always_comb begin
        div_t  = {r_rem[SW-1:0], r_quo[DW-1]};
        div_ge = div_t >= {1'b0, r_sum};
        th_sum = (DW+1)'(r_w) + (DW+1)'(r_quo);
        if (((DW + 1) > TW) && ((th_sum >> TW) != '0)) begin
            th_new = TH_MAX;
        end else begin
            th_new = TW'(th_sum);
        end
        sz_sum = {1'b0, r_sa} + {1'b0, r_sb};
        sz_sat = sz_sum[SW] ? SIZE_MAX : sz_sum[SW-1:0];
    end

    // Next state, memory control and datapath
    always_comb begin
        n_state    = r_state;
        n_ci       = r_ci;
        n_clim     = r_clim;
        n_restart  = r_restart;
        n_sk       = r_sk;
        n_req      = r_req;
        n_na       = r_na;
        n_nb       = r_nb;
        n_w        = r_w;
        n_x        = r_x;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_keep     = r_keep;
        n_sa       = r_sa;
        n_sb       = r_sb;
        n_ta       = r_ta;
        n_tb       = r_tb;
        n_sum      = r_sum;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dcnt     = r_dcnt;
        n_merged   = r_merged;
        n_res_root = r_res_root;
        n_res_size = r_res_size;
        n_ovalid   = r_ovalid && i_stall;
        n_oroot    = r_oroot;
        n_omerged  = r_omerged;
        n_osize    = r_osize;
        p_we = 1'b0; p_waddr = AW'(r_ci); p_wdata = AW'(r_ci);
        s_we = 1'b0; s_waddr = AW'(r_ci); s_wdata = SIZE_ONE;
        t_we = 1'b0; t_waddr = AW'(r_ci); t_wdata = r_sk;
        p_raddr  = r_x;
        st_raddr = r_ra;

        unique case (r_state)
            // sweep nodes to singletons
            gsme_pkg::S_CLEAR: begin
                if (r_ci < r_clim) begin
                    p_we = 1'b1;
                    s_we = 1'b1;
                    t_we = 1'b1;
                    n_ci = r_ci + CW'(1);
                end else begin
                    n_state   = r_restart ? gsme_pkg::S_CHECK : gsme_pkg::S_IDLE;
                    n_restart = 1'b0;
                end
            end
            gsme_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req_type;
                    n_na     = i_node_a;
                    n_nb     = i_node_b;
                    n_w      = i_weight;
                    n_merged = 1'b0;
                    if (i_req_type == gsme_pkg::REQ_RESTART) begin
                        n_state   = gsme_pkg::S_CLEAR;
                        n_ci      = '0;
                        n_clim    = eff_n;
                        n_sk      = f_scale(r_k);
                        n_restart = 1'b1;
                    end else begin
                        n_state = gsme_pkg::S_CHECK;
                    end
                end
            end
            // range check and dispatch
            gsme_pkg::S_CHECK: begin
                if ((EW'(r_na) >= EW'(eff_n)) ||
                    (!r_req[1] && (EW'(r_nb) >= EW'(eff_n)))) begin
                    n_res_root = r_na;
                    n_res_size = '0;
                    n_state    = gsme_pkg::S_DONE;
                end else if (r_req[1]) begin
                    n_x     = AW'(r_na);
                    n_state = gsme_pkg::S_FN_RD;
                end else begin
                    n_x     = AW'(r_na);
                    n_state = gsme_pkg::S_FA_RD;
                end
            end
            // root walk for node_a
            gsme_pkg::S_FA_RD: begin
                n_state = gsme_pkg::S_FA_CK;
            end
            gsme_pkg::S_FA_CK: begin
                if (p_rdata == r_x) begin
                    n_ra    = r_x;
                    n_x     = AW'(r_nb);
                    n_state = gsme_pkg::S_FB_RD;
                end else begin
                    n_x     = p_rdata;
                    n_state = gsme_pkg::S_FA_RD;
                end
            end
            // root walk for node_b
            gsme_pkg::S_FB_RD: begin
                n_state = gsme_pkg::S_FB_CK;
            end
            gsme_pkg::S_FB_CK: begin
                if (p_rdata == r_x) begin
                    n_rb    = r_x;
                    n_state = gsme_pkg::S_RD_A;
                end else begin
                    n_x     = p_rdata;
                    n_state = gsme_pkg::S_FB_RD;
                end
            end
            // fetch size and threshold of both roots
            gsme_pkg::S_RD_A: begin
                st_raddr = r_ra;
                n_state  = gsme_pkg::S_RD_B;
            end
            gsme_pkg::S_RD_B: begin
                st_raddr = r_rb;
                n_sa     = s_rdata;
                n_ta     = t_rdata;
                n_state  = gsme_pkg::S_LAT_B;
            end
            gsme_pkg::S_LAT_B: begin
                n_sb    = s_rdata;
                n_tb    = t_rdata;
                n_state = gsme_pkg::S_EVAL;
            end
            // merge decision and union by size
            gsme_pkg::S_EVAL: begin
                n_x     = AW'(r_na);
                n_state = gsme_pkg::S_FN_RD;
                if ((r_ra != r_rb) &&
                    ((r_req == gsme_pkg::REQ_MERGE &&
                      TW'(r_w) <= r_ta && TW'(r_w) <= r_tb) ||
                     (r_req == gsme_pkg::REQ_SMALL &&
                      (r_sa < r_min || r_sb < r_min)))) begin
                    n_merged = 1'b1;
                    n_keep   = (r_sa < r_sb) ? r_rb : r_ra;
                    p_we     = 1'b1;
                    p_waddr  = (r_sa < r_sb) ? r_ra : r_rb;
                    p_wdata  = (r_sa < r_sb) ? r_rb : r_ra;
                    s_we     = 1'b1;
                    s_waddr  = (r_sa < r_sb) ? r_rb : r_ra;
                    s_wdata  = sz_sat;
                    n_sum    = sz_sat;
                    if (r_req == gsme_pkg::REQ_MERGE) begin
                        n_rem   = '0;
                        n_quo   = DW'(r_k) << FRAC_BITS;
                        n_dcnt  = '0;
                        n_state = gsme_pkg::S_DIV;
                    end
                end
            end
            // restoring division, one quotient bit per cycle
            gsme_pkg::S_DIV: begin
                n_rem  = div_ge ? (div_t - {1'b0, r_sum}) : div_t;
                n_quo  = {r_quo[DW-2:0], div_ge};
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(DW - 1)) begin
                    n_state = gsme_pkg::S_TH_WR;
                end
            end
            gsme_pkg::S_TH_WR: begin
                t_we    = 1'b1;
                t_waddr = r_keep;
                t_wdata = th_new;
                n_state = gsme_pkg::S_FN_RD;
            end
            // final root walk for node_a
            gsme_pkg::S_FN_RD: begin
                n_state = gsme_pkg::S_FN_CK;
            end
            gsme_pkg::S_FN_CK: begin
                if (p_rdata == r_x) begin
                    n_res_root = NW'(r_x);
                    n_state    = gsme_pkg::S_SZ_RD;
                end else begin
                    n_x     = p_rdata;
                    n_state = gsme_pkg::S_FN_RD;
                end
            end
            gsme_pkg::S_SZ_RD: begin
                st_raddr = r_x;
                n_state  = gsme_pkg::S_SZ_LAT;
            end
            gsme_pkg::S_SZ_LAT: begin
                n_res_size = s_rdata;
                n_state    = gsme_pkg::S_DONE;
            end
            // hand result to the output register
            gsme_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_oroot   = r_res_root;
                    n_omerged = r_merged;
                    n_osize   = r_res_size;
                    n_state   = gsme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gsme_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gsme_pkg::S_CLEAR;
            r_ci         <= '0;
            r_clim       <= CW'(MAX_NODES);
            r_restart    <= 1'b0;
            r_sk         <= f_scale(gsme_pkg::K_W'(300));
            r_ovalid     <= 1'b0;
            r_node_count <= SW'(65536);
            r_k          <= gsme_pkg::K_W'(300);
            r_min        <= SW'(1500);
        end else begin
            r_state   <= n_state;
            r_ci      <= n_ci;
            r_clim    <= n_clim;
            r_restart <= n_restart;
            r_sk      <= n_sk;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                unique case (gsme_pkg::t_cfg_idx'(i_cfg_idx))
                    gsme_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    gsme_pkg::CFG_MERGE_K:    r_k <= i_cfg_data[gsme_pkg::K_W-1:0];
                    gsme_pkg::CFG_MIN_SIZE:   r_min <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_na       <= n_na;
        r_nb       <= n_nb;
        r_w        <= n_w;
        r_x        <= n_x;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_keep     <= n_keep;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_ta       <= n_ta;
        r_tb       <= n_tb;
        r_sum      <= n_sum;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dcnt     <= n_dcnt;
        r_merged   <= n_merged;
        r_res_root <= n_res_root;
        r_res_size <= n_res_size;
        r_oroot    <= n_oroot;
        r_omerged  <= n_omerged;
        r_osize    <= n_osize;
    end

    assign o_stall          = (r_state != gsme_pkg::S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_root_label     = r_oroot;
    assign o_merged         = r_omerged;
    assign o_component_size = r_osize;

    // a merge always leaves a component of at least two nodes
    a_merge_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_omerged |-> r_osize >= SW'(2))
        else $error("merged result with component size below two");

    // reset always restarts the clearing sweep
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == gsme_pkg::S_CLEAR)
        else $error("clearing sweep not started after reset");

    // the divider never runs past its quotient width
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gsme_pkg::S_DIV |-> r_dcnt < DCW'(DW))
        else $error("divider step count overrun");

endmodule

[bench/tb_graph_segment_merge_engine_unit.sv]
// Self-checking bench for graph_segment_merge_engine_unit: union-find merges, small pass,
// queries and restarts checked against an in-bench forest tracker.
// Depends on gsme_pkg and the RTL of the engine.

// Expected outcome of one request
typedef struct {
    logic [gsme_pkg::NODE_W-1:0] root;
    logic                        merged;
    logic [gsme_pkg::SIZE_W-1:0] size;
} t_outcome;

// Tracks the forest, the registers and the outcomes still owed by the engine
class forest_tracker;
    logic [gsme_pkg::NODE_W-1:0] parent [gsme_pkg::MAX_NODES_DEF];
    logic [gsme_pkg::SIZE_W-1:0] comp_size [gsme_pkg::MAX_NODES_DEF];
    logic [gsme_pkg::TH_W-1:0]   thresh [gsme_pkg::MAX_NODES_DEF];
    logic [gsme_pkg::CFG_W-1:0]  node_count;
    logic [gsme_pkg::K_W-1:0]    merge_k;
    logic [gsme_pkg::CFG_W-1:0]  min_comp;
    t_outcome                    owed [$];
    int                          errors;
    int                          checked;
    int                          merges;

    function new();
        node_count = 17'd65536;
        merge_k    = 16'd300;
        min_comp   = 17'd1500;
        errors = 0;
        checked = 0;
        merges = 0;
        reinit(gsme_pkg::MAX_NODES_DEF);
    endfunction

    function int active_nodes();
        if (node_count == 0) return 1;
        if (node_count > gsme_pkg::MAX_NODES_DEF) return gsme_pkg::MAX_NODES_DEF;
        return node_count;
    endfunction

    function logic [gsme_pkg::TH_W-1:0] scaled_k();
        longint v;
        v = longint'(merge_k) << gsme_pkg::FRAC_BITS_DEF;
        return (v > 24'hFFFFFF) ? 24'hFFFFFF : v[gsme_pkg::TH_W-1:0];
    endfunction

    function void reinit(int n);
        logic [gsme_pkg::TH_W-1:0] th;
        th = scaled_k();
        for (int i = 0; i < n; i++) begin
            parent[i] = i[gsme_pkg::NODE_W-1:0];
            comp_size[i] = 1;
            thresh[i] = th;
        end
    endfunction

    function int root_of(int x);
        int steps;
        steps = 0;
        while (parent[x] != x && steps < gsme_pkg::MAX_NODES_DEF) begin
            x = parent[x];
            steps++;
        end
        return x;
    endfunction

    // smaller root hangs under larger, ties keep the first
    function int join_roots(int a, int b);
        int keep, lose;
        int sum;
        keep = a;
        lose = b;
        if (comp_size[a] < comp_size[b]) begin
            keep = b;
            lose = a;
        end
        parent[lose] = keep[gsme_pkg::NODE_W-1:0];
        sum = comp_size[keep] + comp_size[lose];
        comp_size[keep] = (sum > 'h1FFFF) ? 17'h1FFFF : sum[gsme_pkg::SIZE_W-1:0];
        return keep;
    endfunction

    function void write_reg(gsme_pkg::t_cfg_idx idx, logic [gsme_pkg::CFG_W-1:0] val);
        case (idx)
            gsme_pkg::CFG_NODE_COUNT: node_count = val;
            gsme_pkg::CFG_MERGE_K:    merge_k = val[gsme_pkg::K_W-1:0];
            gsme_pkg::CFG_MIN_SIZE:   min_comp = val;
            default: ;
        endcase
    endfunction

    // Apply one accepted request and queue the outcome
    function void note_request(gsme_pkg::t_req rq, int a, int b, int w);
        t_outcome o;
        int n, ra, rb, r;
        longint t;
        o.merged = 1'b0;
        if (rq == gsme_pkg::REQ_RESTART) reinit(active_nodes());
        n = active_nodes();
        if (a >= n ||
            ((rq == gsme_pkg::REQ_MERGE || rq == gsme_pkg::REQ_SMALL) && b >= n)) begin
            o.root = a[gsme_pkg::NODE_W-1:0];
            o.size = '0;
            owed.push_back(o);
            return;
        end
        if (rq == gsme_pkg::REQ_MERGE || rq == gsme_pkg::REQ_SMALL) begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra != rb) begin
                if (rq == gsme_pkg::REQ_MERGE) begin
                    if (w <= thresh[ra] && w <= thresh[rb]) begin
                        r = join_roots(ra, rb);
                        t = longint'(w) + ((longint'(merge_k) << gsme_pkg::FRAC_BITS_DEF)
                            / comp_size[r]);
                        thresh[r] = (t > 24'hFFFFFF) ? 24'hFFFFFF : t[gsme_pkg::TH_W-1:0];
                        o.merged = 1'b1;
                    end
                end else if (comp_size[ra] < min_comp || comp_size[rb] < min_comp) begin
                    void'(join_roots(ra, rb));
                    o.merged = 1'b1;
                end
            end
        end
        ra = root_of(a);
        o.root = ra[gsme_pkg::NODE_W-1:0];
        o.size = comp_size[ra];
        owed.push_back(o);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [gsme_pkg::NODE_W-1:0] root, logic merged,
                      logic [gsme_pkg::SIZE_W-1:0] size);
        t_outcome o;
        checked++;
        if (owed.size() == 0) begin
            report($sformatf("unexpected result root=%0d", root));
            return;
        end
        o = owed.pop_front();
        if (o.merged) merges++;
        if (root !== o.root)
            report($sformatf("root_label %0d, expected %0d", root, o.root));
        if (merged !== o.merged)
            report($sformatf("merged %0b, expected %0b", merged, o.merged));
        if (size !== o.size)
            report($sformatf("component_size %0d, expected %0d", size, o.size));
    endtask
endclass

module tb_graph_segment_merge_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [1:0]                  i_cfg_idx = '0;
    logic [gsme_pkg::CFG_W-1:0]  i_cfg_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_req_type = '0;
    logic [gsme_pkg::NODE_W-1:0] i_node_a = '0;
    logic [gsme_pkg::NODE_W-1:0] i_node_b = '0;
    logic [gsme_pkg::WGT_W-1:0]  i_weight = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [gsme_pkg::NODE_W-1:0] o_root_label;
    logic                        o_merged;
    logic [gsme_pkg::SIZE_W-1:0] o_component_size;

    forest_tracker forest;
    int send_idle_pct;
    int recv_idle_pct;
    int sent;
    int cur_w;
    int n_tab [6] = '{16, 1, 65536, 64, 200, 32};
    int k_tab [6] = '{300, 0, 65535, 1000, 50, 65535};
    int m_tab [6] = '{4, 0, 65536, 20, 8, 65536};

    graph_segment_merge_engine_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_weight(i_weight),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_root_label(o_root_label), .o_merged(o_merged),
        .o_component_size(o_component_size)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random stall, check every taken result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            forest.check_result(o_root_label, o_merged, o_component_size);
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task wait_drained();
        while (forest.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write all three registers back to back while the engine is idle
    task program_regs(int n, int k, int min_sz);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= gsme_pkg::CFG_NODE_COUNT;
        i_cfg_data <= n[gsme_pkg::CFG_W-1:0];
        forest.write_reg(gsme_pkg::CFG_NODE_COUNT, n[gsme_pkg::CFG_W-1:0]);
        @(posedge i_clk);
        i_cfg_idx <= gsme_pkg::CFG_MERGE_K;
        i_cfg_data <= k[gsme_pkg::CFG_W-1:0];
        forest.write_reg(gsme_pkg::CFG_MERGE_K, k[gsme_pkg::CFG_W-1:0]);
        @(posedge i_clk);
        i_cfg_idx <= gsme_pkg::CFG_MIN_SIZE;
        i_cfg_data <= min_sz[gsme_pkg::CFG_W-1:0];
        forest.write_reg(gsme_pkg::CFG_MIN_SIZE, min_sz[gsme_pkg::CFG_W-1:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Present one request and hold it until taken
    task send(gsme_pkg::t_req rq, int a, int b, int w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rq;
        i_node_a <= a[gsme_pkg::NODE_W-1:0];
        i_node_b <= b[gsme_pkg::NODE_W-1:0];
        i_weight <= w[gsme_pkg::WGT_W-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        forest.note_request(rq, a, b, w);
        sent++;
    endtask

    // Mostly ascending-weight edges inside the node range, some noise
    task random_request(bit allow_restart);
        int n, sel, a, b;
        n = forest.active_nodes();
        sel = $urandom_range(99);
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        if (sel < 55) begin
            cur_w += $urandom_range(0, 600);
            if (cur_w > 65535) cur_w = 65535;
            send(gsme_pkg::REQ_MERGE, a, b, cur_w);
        end else if (sel < 70) begin
            send(gsme_pkg::REQ_SMALL, a, b, $urandom_range(65535));
        end else if (sel < 84) begin
            send(gsme_pkg::REQ_QUERY, a, $urandom_range(65535), $urandom_range(65535));
        end else if (sel < 89 && allow_restart) begin
            cur_w = 0;
            send(gsme_pkg::REQ_RESTART, a, $urandom_range(65535), $urandom_range(65535));
        end else begin
            send(gsme_pkg::t_req'($urandom_range(2)), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(65535));
        end
    endtask

    initial begin
        forest = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent = 0;
        cur_w = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a small forest with every request kind and edge case
        program_regs(8, 300, 3);
        send(gsme_pkg::REQ_RESTART, 0, 0, 0);
        send(gsme_pkg::REQ_MERGE, 0, 1, 0);
        send(gsme_pkg::REQ_MERGE, 1, 0, 5);            // already joined
        send(gsme_pkg::REQ_MERGE, 2, 3, 65535);        // above both thresholds
        send(gsme_pkg::REQ_MERGE, 2, 3, 38400);        // exactly at threshold
        send(gsme_pkg::REQ_MERGE, 0, 2, 38401);
        send(gsme_pkg::REQ_SMALL, 4, 5, 0);
        send(gsme_pkg::REQ_SMALL, 0, 4, 0);            // size 2 below min joins
        send(gsme_pkg::REQ_SMALL, 6, 7, 65535);
        send(gsme_pkg::REQ_SMALL, 0, 6, 0);
        send(gsme_pkg::REQ_QUERY, 7, 65535, 0);
        send(gsme_pkg::REQ_MERGE, 65535, 0, 0);        // node_a out of range
        send(gsme_pkg::REQ_MERGE, 0, 65535, 0);        // node_b out of range
        send(gsme_pkg::REQ_SMALL, 7, 8, 0);
        send(gsme_pkg::REQ_QUERY, 8, 0, 0);
        send(gsme_pkg::REQ_QUERY, 5, 65535, 0);        // node_b ignored on query
        send(gsme_pkg::REQ_RESTART, 9, 0, 0);          // restart, node_a out of range
        send(gsme_pkg::REQ_RESTART, 7, 0, 0);
        send(gsme_pkg::REQ_MERGE, 7, 0, 0);
        send(gsme_pkg::REQ_QUERY, 0, 0, 0);

        // Random phases over several register settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 54 : 0;
            recv_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 26 : 0;
            i_valid <= 1'b0;
            program_regs(n_tab[ph], k_tab[ph], m_tab[ph]);
            cur_w = 0;
            // full-size forest restarts once, in its directed opening
            send(gsme_pkg::REQ_RESTART, 0, 0, 0);
            for (int i = 0; i < 247; i++) begin
                if (ph == 0 && i == 100) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                random_request(n_tab[ph] != 65536);
            end
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d requests, %0d results checked, %0d joins, six register settings.",
                 sent, forest.checked, forest.merges);
        if (forest.errors == 0 && forest.owed.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
